>>> design/bfa_pkg.sv
// Shared types and constants for the bitmap frame allocator.
package bfa_pkg;

    // Widths fixed by the request and result words
    localparam int FRAME_W      = 12;
    localparam int LIMIT_W      = 13;
    localparam int STATUS_W     = 2;
    // Bytes searched never exceed 4096 / 8 = 512, so this holds 0 to 512
    localparam int IDX_W        = 10;
    localparam int FIELD_FRAMES = 4096;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;
    localparam logic [7:0] BYTE_FULL = 8'hFF;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOOP   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOFREE = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE
    } state_t;

    typedef struct packed {
        logic               command;
        logic [FRAME_W-1:0] page_frame;
        logic               kernel_page;
        logic               rw_page;
    } request_t;

    typedef struct packed {
        logic [FRAME_W-1:0]  new_frame;
        logic                present_bit;
        logic                writable_bit;
        logic                user_bit;
        logic [STATUS_W-1:0] status;
    } result_t;

    // What the byte examiner reports about one bitmap byte
    typedef struct packed {
        logic       full;
        logic [2:0] bit_idx;
    } scan_t;

endpackage

>>> design/bfa_map_mem.sv
// Single-port-write, registered-read memory holding the used/free bitmap.
module bfa_map_mem #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/bfa_byte_scan.sv
// Byte examiner: finds the lowest free frame within one bitmap byte.
module bfa_byte_scan (
    input  logic          [7:0] byte_in,
    output bfa_pkg::scan_t      scan
);

    always_comb
    begin
        scan.full    = (byte_in == bfa_pkg::BYTE_FULL);
        scan.bit_idx = 3'd0;
        // Walk from the top so that the lowest clear bit wins.
        for (int b = 7; b >= 0; b--)
        begin
            if (!byte_in[b])
            begin
                scan.bit_idx = 3'(b);
            end
        end
    end

endmodule

>>> design/bitmap_frame_allocator_unit.sv
// Top level of the bitmap frame allocator: sequencer, bitmap memory and byte examiner.
//
//  Channel    | Handshake           | Word
//  -----------+---------------------+----------------------------------------
//  request    | start, busy         | command, page_frame, kernel_page, rw_page
//  result     | done (one cycle)    | new_frame, present/writable/user bits, status
//  config     | cfg_we              | cfg_wdata = frame_limit
//
// After reset a clearing pass writes all (NUM_FRAMES + 7) / 8 bitmap bytes
// (512 by default) to zero; busy is high throughout.
// A search reads one bitmap byte per cycle from the memory's registered read
// port and stops at the first byte with a clear bit, or after the last byte
// below the limit. A free reads its byte on acceptance and clears the frame's
// bit on write-back; trivial requests raise done at the accepting edge itself.
// The receiver cannot stall: done marks each result for exactly one cycle.
module bitmap_frame_allocator_unit #(
    parameter int NUM_FRAMES = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  bfa_pkg::request_t                    request,
    output logic                                 done,
    output bfa_pkg::result_t                     result,
    input  logic                                 cfg_we,
    input  logic [bfa_pkg::LIMIT_W-1:0]          cfg_wdata
);

    localparam int LW         = bfa_pkg::LIMIT_W;
    localparam int IW         = bfa_pkg::IDX_W;
    localparam int MAP_BYTES  = (NUM_FRAMES + 7) / 8;
    localparam int ADDR_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CAP_FRAMES = (NUM_FRAMES < bfa_pkg::FIELD_FRAMES) ?
                                NUM_FRAMES : bfa_pkg::FIELD_FRAMES;
    localparam logic [LW-1:0]     CAP_LIMIT = LW'(CAP_FRAMES);
    localparam logic [16:0]       FRAME_END = 17'(NUM_FRAMES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);

    bfa_pkg::state_t   state_reg, state_next;
    logic [LW-1:0]     limit_reg;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [IW-1:0]     issue_idx_reg, issue_idx_next;
    logic [IW-1:0]     data_idx_reg, data_idx_next;
    logic              rd_valid_reg, rd_valid_next;
    bfa_pkg::request_t req_reg, req_next;
    logic              done_reg, done_next;
    bfa_pkg::result_t  result_reg, result_next;

    logic [LW-1:0]     eff_limit;
    logic [IW-1:0]     scan_bytes;
    logic              last_byte;
    logic              frame_ok;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [7:0]        mem_wr_data;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [7:0]        mem_rd_data;
    bfa_pkg::scan_t    scan;
    logic [7:0]        set_mask;
    logic [7:0]        clr_mask;

    bfa_map_mem #(
        .DEPTH  (MAP_BYTES),
        .ADDR_W (ADDR_W)
    ) u_map (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    bfa_byte_scan u_scan (
        .byte_in (mem_rd_data),
        .scan    (scan)
    );

    // Search covers whole bytes below the smaller of the limit and the map size.
    assign eff_limit  = (limit_reg > CAP_LIMIT) ? CAP_LIMIT : limit_reg;
    assign scan_bytes = eff_limit[LW-1:3];
    assign last_byte  = (data_idx_reg == (scan_bytes - IW'(1)));
    assign frame_ok   = (request.page_frame != '0) &&
                        ({5'd0, request.page_frame} < FRAME_END);
    assign set_mask   = 8'd1 << scan.bit_idx;
    assign clr_mask   = ~(8'd1 << req_reg.page_frame[2:0]);

    assign busy   = (state_reg != bfa_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfa_pkg::S_CLEAR;
            limit_reg     <= bfa_pkg::LIMIT_RESET;
            clr_addr_reg  <= '0;
            issue_idx_reg <= '0;
            rd_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            issue_idx_reg <= issue_idx_next;
            rd_valid_reg  <= rd_valid_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_idx_reg <= data_idx_next;
        req_reg      <= req_next;
        result_reg   <= result_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfa_pkg::S_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = bfa_pkg::S_IDLE;
                end
            end
            bfa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (request.command == bfa_pkg::CMD_ALLOC)
                    begin
                        if (request.page_frame == '0 && scan_bytes != '0)
                        begin
                            state_next = bfa_pkg::S_SCAN;
                        end
                    end
                    else if (frame_ok)
                    begin
                        state_next = bfa_pkg::S_FREE;
                    end
                end
            end
            bfa_pkg::S_SCAN:
            begin
                if (rd_valid_reg && (!scan.full || last_byte))
                begin
                    state_next = bfa_pkg::S_IDLE;
                end
            end
            bfa_pkg::S_FREE:
            begin
                state_next = bfa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bfa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_addr_next  = clr_addr_reg;
        issue_idx_next = issue_idx_reg;
        data_idx_next  = data_idx_reg;
        rd_valid_next  = rd_valid_reg;
        req_next       = req_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = clr_addr_reg;
        mem_wr_data    = 8'd0;
        mem_rd_addr    = ADDR_W'(issue_idx_reg);
        case (state_reg)
            bfa_pkg::S_CLEAR:
            begin
                mem_wr_en     = 1'b1;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            bfa_pkg::S_IDLE:
            begin
                // A free reads its byte straight away, so the data is ready next cycle.
                mem_rd_addr = ADDR_W'(request.page_frame[bfa_pkg::FRAME_W-1:3]);
                if (start)
                begin
                    req_next       = request;
                    issue_idx_next = '0;
                    rd_valid_next  = 1'b0;
                    result_next    = '0;
                    if (request.command == bfa_pkg::CMD_ALLOC)
                    begin
                        if (request.page_frame != '0)
                        begin
                            done_next             = 1'b1;
                            result_next.new_frame = request.page_frame;
                            result_next.status    = bfa_pkg::STAT_NOOP;
                        end
                        else if (scan_bytes == '0)
                        begin
                            done_next          = 1'b1;
                            result_next.status = bfa_pkg::STAT_NOFREE;
                        end
                    end
                    else if (!frame_ok)
                    begin
                        done_next          = 1'b1;
                        result_next.status = bfa_pkg::STAT_NOOP;
                    end
                end
            end
            bfa_pkg::S_SCAN:
            begin
                if (issue_idx_reg < scan_bytes)
                begin
                    issue_idx_next = issue_idx_reg + IW'(1);
                    data_idx_next  = issue_idx_reg;
                    rd_valid_next  = 1'b1;
                end
                else
                begin
                    rd_valid_next = 1'b0;
                end
                if (rd_valid_reg)
                begin
                    if (!scan.full)
                    begin
                        mem_wr_en                = 1'b1;
                        mem_wr_addr              = ADDR_W'(data_idx_reg);
                        mem_wr_data              = mem_rd_data | set_mask;
                        done_next                = 1'b1;
                        result_next.new_frame    = {data_idx_reg[IW-2:0], scan.bit_idx};
                        result_next.present_bit  = 1'b1;
                        result_next.writable_bit = req_reg.rw_page;
                        result_next.user_bit     = ~req_reg.kernel_page;
                        result_next.status       = bfa_pkg::STAT_DONE;
                    end
                    else if (last_byte)
                    begin
                        done_next          = 1'b1;
                        result_next        = '0;
                        result_next.status = bfa_pkg::STAT_NOFREE;
                    end
                end
            end
            bfa_pkg::S_FREE:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ADDR_W'(req_reg.page_frame[bfa_pkg::FRAME_W-1:3]);
                mem_wr_data = mem_rd_data & clr_mask;
                done_next   = 1'b1;
                result_next        = '0;
                result_next.status = bfa_pkg::STAT_DONE;
            end
            default:
            begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

endmodule

>>> design/bfa_checker.sv
// Port-level checks for the bitmap frame allocator, bound to the top level.
module bfa_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input bfa_pkg::result_t result
);

    // An accepted word is either answered at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted request neither answered nor in progress");

    // A result is only given once the sequencer has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    // Only a successful allocation sets the page entry bits.
    a_bits_on_success: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != bfa_pkg::STAT_DONE |->
            !result.present_bit && !result.writable_bit && !result.user_bit)
        else $error("page entry bits set on a failed or empty request");

    // An exhausted bitmap returns frame zero.
    a_nofree_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == bfa_pkg::STAT_NOFREE |-> result.new_frame == '0)
        else $error("no-free-frame result carries a frame number");

    // The clearing pass keeps the block busy as reset is released.
    a_clear_busy: assert property (@(posedge clk)
        $rose(rst_n) |-> busy)
        else $error("block ready before the bitmap was cleared");

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
